/* rtl/lzwd_pkg.sv */
// ----------------------------------------------------------------------------
// LZ77 window decompressor package
// Shared types, field widths and result codes of the LZSS stream decoder.
// ----------------------------------------------------------------------------
package lzwd_pkg;

   // field widths fixed by the stream format
   localparam int BYTE_W = 8;
   localparam int SIZE_W = 24;
   localparam int LEN_W  = 5;    // match length 3..18
   localparam int DIST_W = 13;   // match distance 1..4096
   localparam int STAT_W = 2;
   localparam int USER_W = 1 + STAT_W;

   localparam logic [BYTE_W-1:0] TAG_MSB  = 8'h80;
   localparam logic [LEN_W-1:0]  LEN_BIAS = 5'd3;

   // result status codes
   localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
   localparam logic [STAT_W-1:0] ST_OVERRUN   = 2'd1;
   localparam logic [STAT_W-1:0] ST_BAD_DIST  = 2'd2;
   localparam logic [STAT_W-1:0] ST_EARLY_END = 2'd3;

   // what the next compressed byte is
   typedef enum logic [1:0] {
      PH_TAG    = 2'd0,
      PH_ITEM   = 2'd1,
      PH_SECOND = 2'd2
   } phase_type;

endpackage

/* rtl/lzwd_ram.sv */
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lzwd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/lz77_window_decompressor_top.sv */
// ----------------------------------------------------------------------------
// LZ77 window decompressor
// Decodes an LZSS (LZ10) byte stream, header removed, into plain bytes.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  req     | in  | req_tvalid/tready    | tdata = data_byte, tlast = last_byte
//  rsp     | out | rsp_tvalid/tready    | tdata = out_byte, tlast = last_of_run,
//          |     |                      | tuser = {status, finished}
//  csr     | in  | csr_valid/csr_ready  | csr_data = output_size (arms a stream)
//
// The second byte of a match starts a copy: the history RAM has a single
// read port and yields one window byte per cycle while the output register
// is free, and no new request is taken until the copy ends.
// Reset clears control state but not the copy source, its flags or the RAM.
// A stalled rsp channel holds the decoder; a new request is taken only while
// the output register is free or being drained.
// ----------------------------------------------------------------------------
module lz77_window_decompressor_top #(
   parameter int WINDOW_DEPTH = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   // request: data_byte[7:0]
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [lzwd_pkg::BYTE_W-1:0]   req_tdata,
   input  logic                          req_tlast,
   // response: out_byte[7:0]
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [lzwd_pkg::BYTE_W-1:0]   rsp_tdata,
   output logic                          rsp_tlast,
   // response user: finished[0], status[2:1]
   output logic [lzwd_pkg::USER_W-1:0]   rsp_tuser,
   // configuration: output_size[23:0]
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [lzwd_pkg::SIZE_W-1:0]   csr_data
);
   import lzwd_pkg::*;

   localparam int AW = $clog2(WINDOW_DEPTH);

   typedef enum logic {
      S_IDLE,
      S_COPY
   } state_type;

   state_type            state_ff,        state_in;
   phase_type            phase_ff,        phase_in;
   logic [BYTE_W-1:0]    flag_byte_ff,    flag_byte_in;
   logic [BYTE_W-1:0]    flag_mask_ff,    flag_mask_in;
   logic [BYTE_W-1:0]    match_first_ff,  match_first_in;
   logic [SIZE_W-1:0]    produced_ff,     produced_in;
   logic [SIZE_W-1:0]    size_ff,         size_in;
   logic                 failed_ff,       failed_in;
   logic [AW-1:0]        src_ff,          src_in;
   logic [LEN_W-1:0]     remain_ff,       remain_in;
   logic                 dist_one_ff,     dist_one_in;
   logic                 first_ff,        first_in;
   logic                 rsp_valid_ff,    rsp_valid_in;
   logic [BYTE_W-1:0]    rsp_data_ff,     rsp_data_in;
   logic                 rsp_last_ff,     rsp_last_in;
   logic                 rsp_fin_ff,      rsp_fin_in;
   logic [STAT_W-1:0]    rsp_stat_ff,     rsp_stat_in;

   logic                 out_free;
   logic                 req_fire;
   logic                 active;
   logic                 copy_load;
   logic [LEN_W-1:0]     match_len;
   logic [DIST_W-1:0]    match_dist;
   logic [SIZE_W:0]      end_lit;
   logic [SIZE_W:0]      end_match;
   logic [SIZE_W:0]      size_wide;
   logic [SIZE_W:0]      produced_wide;
   logic [SIZE_W:0]      dist_wide;
   logic [BYTE_W-1:0]    next_mask;
   logic [BYTE_W-1:0]    copy_byte;
   logic [SIZE_W-1:0]    produced_inc;
   logic                 ram_wen;
   logic [BYTE_W-1:0]    ram_wdata;
   logic [AW-1:0]        ram_raddr;
   logic [BYTE_W-1:0]    ram_rdata;

   // handshake helpers
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && out_free;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign active     = !failed_ff && (produced_ff < size_ff);
   assign copy_load  = (state_ff == S_COPY) && out_free;

   // decode the match from its two bytes
   assign match_len     = {1'b0, match_first_ff[7:4]} + LEN_BIAS;
   assign match_dist    = {1'b0, match_first_ff[3:0], req_tdata} + DIST_W'(1);
   assign size_wide     = {1'b0, size_ff};
   assign produced_wide = {1'b0, produced_ff};
   assign dist_wide     = (SIZE_W+1)'(match_dist);
   assign end_lit       = produced_wide + (SIZE_W+1)'(1);
   assign end_match     = produced_wide + (SIZE_W+1)'(match_len);
   assign next_mask     = flag_mask_ff >> 1;
   assign produced_inc  = produced_ff + SIZE_W'(1);

   // a distance of one repeats the byte just produced, which the RAM
   // cannot return yet
   assign copy_byte = (dist_one_ff && !first_ff) ? rsp_data_ff : ram_rdata;

   // history RAM access
   always_comb begin
      if (state_ff == S_COPY) begin
         ram_wen   = copy_load;
         ram_wdata = copy_byte;
         ram_raddr = copy_load ? (src_ff + AW'(1)) : src_ff;
      end else begin
         ram_wen   = req_fire && active && (phase_ff == PH_ITEM)
                     && ((flag_byte_ff & flag_mask_ff) == '0)
                     && !(req_tlast && (end_lit < size_wide));
         ram_wdata = req_tdata;
         ram_raddr = produced_ff[AW-1:0] - match_dist[AW-1:0];
      end
   end

   lzwd_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (WINDOW_DEPTH)
   ) u_history (
      .clock   (clock),
      .wr_en   (ram_wen),
      .wr_addr (produced_ff[AW-1:0]),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // next-state logic of the decoder
   always_comb begin
      logic              err_hit;
      logic [STAT_W-1:0] err_code;

      state_in       = state_ff;
      phase_in       = phase_ff;
      flag_byte_in   = flag_byte_ff;
      flag_mask_in   = flag_mask_ff;
      match_first_in = match_first_ff;
      produced_in    = produced_ff;
      size_in        = size_ff;
      failed_in      = failed_ff;
      src_in         = src_ff;
      remain_in      = remain_ff;
      dist_one_in    = dist_one_ff;
      first_in       = first_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_data_in    = rsp_data_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_fin_in     = rsp_fin_ff;
      rsp_stat_in    = rsp_stat_ff;
      err_hit        = 1'b0;
      err_code       = ST_OK;

      if (state_ff == S_COPY) begin
         // emit one window byte per cycle while the output register is free
         if (copy_load) begin
            produced_in  = produced_inc;
            src_in       = src_ff + AW'(1);
            remain_in    = remain_ff - LEN_W'(1);
            first_in     = 1'b0;
            rsp_valid_in = 1'b1;
            rsp_data_in  = copy_byte;
            rsp_last_in  = (remain_ff == LEN_W'(1));
            rsp_fin_in   = (produced_inc == size_ff);
            rsp_stat_in  = ST_OK;
            if (remain_ff == LEN_W'(1)) begin
               state_in = S_IDLE;
            end
         end
      end else if (req_fire && active) begin
         unique case (phase_ff)
            PH_ITEM: begin
               if ((flag_byte_ff & flag_mask_ff) != '0) begin
                  // first byte of a match
                  if (req_tlast) begin
                     err_hit  = 1'b1;
                     err_code = ST_EARLY_END;
                  end else begin
                     match_first_in = req_tdata;
                     phase_in       = PH_SECOND;
                  end
               end else if (req_tlast && (end_lit < size_wide)) begin
                  err_hit  = 1'b1;
                  err_code = ST_EARLY_END;
               end else begin
                  // literal
                  produced_in  = produced_inc;
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = req_tdata;
                  rsp_last_in  = 1'b1;
                  rsp_fin_in   = (end_lit == size_wide);
                  rsp_stat_in  = ST_OK;
                  flag_mask_in = next_mask;
                  phase_in     = (next_mask != '0) ? PH_ITEM : PH_TAG;
               end
            end
            PH_SECOND: begin
               if (end_match > size_wide) begin
                  err_hit  = 1'b1;
                  err_code = ST_OVERRUN;
               end else if (dist_wide > produced_wide) begin
                  err_hit  = 1'b1;
                  err_code = ST_BAD_DIST;
               end else if (req_tlast && (end_match < size_wide)) begin
                  err_hit  = 1'b1;
                  err_code = ST_EARLY_END;
               end else begin
                  // start the copy; the first read is already issued
                  state_in     = S_COPY;
                  src_in       = ram_raddr;
                  remain_in    = match_len;
                  dist_one_in  = (match_dist == DIST_W'(1));
                  first_in     = 1'b1;
                  flag_mask_in = next_mask;
                  phase_in     = (next_mask != '0) ? PH_ITEM : PH_TAG;
               end
            end
            default: begin
               // tag byte, also taken for the unused phase code
               if (req_tlast) begin
                  err_hit  = 1'b1;
                  err_code = ST_EARLY_END;
               end else begin
                  flag_byte_in = req_tdata;
                  flag_mask_in = TAG_MSB;
                  phase_in     = PH_ITEM;
               end
            end
         endcase

         // report an error as a single terminal result
         if (err_hit) begin
            failed_in    = 1'b1;
            rsp_valid_in = 1'b1;
            rsp_data_in  = '0;
            rsp_last_in  = 1'b1;
            rsp_fin_in   = 1'b0;
            rsp_stat_in  = err_code;
         end
      end

      // a size write arms a new stream
      if (csr_valid && csr_ready) begin
         size_in        = csr_data;
         state_in       = S_IDLE;
         phase_in       = PH_TAG;
         flag_byte_in   = '0;
         flag_mask_in   = '0;
         match_first_in = '0;
         produced_in    = '0;
         failed_in      = 1'b0;
      end
   end

   // hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         phase_ff       <= PH_TAG;
         flag_byte_ff   <= '0;
         flag_mask_ff   <= '0;
         match_first_ff <= '0;
         produced_ff    <= '0;
         size_ff        <= '0;
         failed_ff      <= 1'b0;
         remain_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         phase_ff       <= phase_in;
         flag_byte_ff   <= flag_byte_in;
         flag_mask_ff   <= flag_mask_in;
         match_first_ff <= match_first_in;
         produced_ff    <= produced_in;
         size_ff        <= size_in;
         failed_ff      <= failed_in;
         remain_ff      <= remain_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      src_ff      <= src_in;
      dist_one_ff <= dist_one_in;
      first_ff    <= first_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      rsp_fin_ff  <= rsp_fin_in;
      rsp_stat_ff <= rsp_stat_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = {rsp_stat_ff, rsp_fin_ff};

   // never produce more bytes than the stream asks for
   a_count_in_size: assert property (@(posedge clock) disable iff (reset)
      produced_ff <= size_ff)
      else $error("produced count passed output size");

   // a copy in flight always has bytes left
   a_copy_remain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_COPY) |-> (remain_ff != '0))
      else $error("copy state with zero bytes left");

   // every byte written to the window is also presented as a result
   a_write_emits: assert property (@(posedge clock) disable iff (reset)
      ram_wen |=> rsp_tvalid)
      else $error("history write without a result");

endmodule

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// LZ77 window decompressor testbench
// Streams LZSS byte sequences through the decoder and checks every output byte,
// its run marker, finished flag and status against a built-in decoder model.
// Covers literals, matches, all error codes, size extremes, trailing bytes
// and a long receiver stall that backs up the input.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lzwd_pkg::*;

   localparam int WINDOW      = 4096;
   localparam int IDLE_GAP    = 25;      // longest match drain plus margin
   localparam int HOLD_CYCLES = 400;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_REQS = 100;

   // one predicted output byte, laid out like the rsp channel
   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              last;
      logic              finished;
      logic [STAT_W-1:0] status;
   } rsp_item_type;

   // one compressed byte to send
   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              last;
   } comp_byte_type;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [BYTE_W-1:0]   req_tdata  = '0;
   logic                req_tlast  = 1'b0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [BYTE_W-1:0]   rsp_tdata;
   logic                rsp_tlast;
   logic [USER_W-1:0]   rsp_tuser;
   logic                csr_valid  = 1'b0;
   logic                csr_ready;
   logic [SIZE_W-1:0]   csr_data   = '0;

   // decoder model state
   phase_type           dec_phase  = PH_TAG;
   logic [BYTE_W-1:0]   dec_flags  = '0;
   logic [BYTE_W-1:0]   dec_mask   = '0;
   logic [BYTE_W-1:0]   dec_first  = '0;
   logic [SIZE_W-1:0]   dec_count  = '0;
   logic [SIZE_W-1:0]   dec_size   = '0;
   logic                dec_failed = 1'b0;
   logic [BYTE_W-1:0]   hist [WINDOW];

   rsp_item_type        run_q[$];
   rsp_item_type        decoded_q[$];
   comp_byte_type       comp_stream[$];

   bit                  idle_on = 1'b1;
   bit                  holding = 1'b0;
   event                hold_trigger;
   int unsigned         cycle_count   = 0;
   int unsigned         live_items    = 0;
   int unsigned         rsp_checked   = 0;
   int unsigned         mismatches    = 0;
   int unsigned         streams_armed = 0;
   int unsigned         status_seen [4];

   lz77_window_decompressor_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // data_byte[7:0]
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),    // out_byte[7:0]
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),    // finished[0], status[2:1]
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)      // output_size[23:0]
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: timeout after %0d cycles", cycle_count);
         $display("tb: FAIL");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // decoder model
   // ------------------------------------------------------------------------

   // write one output byte into the window and queue its result
   function automatic void push_out(input logic [BYTE_W-1:0] b);
      rsp_item_type item;
      hist[dec_count % WINDOW] = b;
      dec_count = dec_count + 1'b1;
      item = '{data: b, last: 1'b0, finished: (dec_count == dec_size), status: ST_OK};
      run_q.insert(run_q.size(), item);
   endfunction

   // advance to the next flag, fetch a new tag when all eight are used
   function automatic void next_flag();
      dec_mask  = dec_mask >> 1;
      dec_phase = (dec_mask != '0) ? PH_ITEM : PH_TAG;
   endfunction

   // decode one accepted request and queue the bytes it yields
   function automatic void decode_byte(input logic [BYTE_W-1:0] b, input logic l);
      logic [LEN_W-1:0]  len;
      logic [DIST_W-1:0] distance;
      logic [SIZE_W:0]   reach;
      logic [SIZE_W-1:0] src;
      logic [STAT_W-1:0] err;
      int                i;
      err = ST_OK;
      if (dec_failed || dec_count >= dec_size) return;
      live_items++;
      run_q.delete();
      case (dec_phase)
         PH_ITEM: begin
            if ((dec_flags & dec_mask) != '0) begin
               dec_first = b;
               dec_phase = PH_SECOND;
            end else begin
               push_out(b);
               next_flag();
            end
         end
         PH_SECOND: begin
            len      = {1'b0, dec_first[7:4]} + LEN_BIAS;
            distance = {1'b0, dec_first[3:0], b} + 1'b1;
            reach    = {1'b0, dec_count} + len;
            if (reach > {1'b0, dec_size}) begin
               err = ST_OVERRUN;
            end else if (SIZE_W'(distance) > dec_count) begin
               err = ST_BAD_DIST;
            end else begin
               // overlapping copy: source moves with the write pointer
               for (i = 0; i < len; i++) begin
                  src = dec_count - SIZE_W'(distance);
                  push_out(hist[src % WINDOW]);
               end
               next_flag();
            end
         end
         default: begin
            dec_flags = b;
            dec_mask  = TAG_MSB;
            dec_phase = PH_ITEM;
         end
      endcase
      if (err == ST_OK && l && dec_count < dec_size) err = ST_EARLY_END;
      if (err != ST_OK) begin
         // drop the data bytes, report one error byte
         dec_failed = 1'b1;
         run_q.delete();
         run_q.insert(0, rsp_item_type'{data: '0, last: 1'b1, finished: 1'b0,
                                        status: err});
      end else if (run_q.size() != 0) begin
         run_q[$].last = 1'b1;
      end
      decoded_q = {decoded_q, run_q};
   endfunction

   // ------------------------------------------------------------------------
   // response side
   // ------------------------------------------------------------------------

   // random back-pressure, forced low during a long hold
   always @(negedge clock) begin
      if (holding)
         rsp_tready <= 1'b0;
      else if (idle_on)
         rsp_tready <= ($urandom_range(99) >= 16);
      else
         rsp_tready <= 1'b1;
   end

   // count out a long receiver hold
   initial begin
      forever begin
         @(hold_trigger);
         holding = 1'b1;
         repeat (HOLD_CYCLES) @(negedge clock);
         holding = 1'b0;
      end
   end

   function automatic void log_mismatch(input string what, input rsp_item_type want,
                                        input rsp_item_type got);
      mismatches++;
      if (mismatches <= 10)
         $display("tb: %s at cycle %0d: exp data=%02h last=%b fin=%b st=%0d, got data=%02h last=%b fin=%b st=%0d",
                  what, cycle_count, want.data, want.last, want.finished, want.status,
                  got.data, got.last, got.finished, got.status);
   endfunction

   // compare each response against the oldest predicted byte
   always @(posedge clock) begin : check_rsp
      rsp_item_type want;
      rsp_item_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{data: rsp_tdata, last: rsp_tlast, finished: rsp_tuser[0],
                 status: rsp_tuser[2:1]};
         rsp_checked++;
         status_seen[got.status]++;
         if (decoded_q.size() == 0) begin
            log_mismatch("unexpected response", got, got);
         end else begin
            want = decoded_q.pop_front();
            if (got !== want) log_mismatch("field mismatch", want, got);
         end
      end
   end

   // ------------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------------

   // offer one compressed byte, hold it until taken
   task automatic send_item(input logic [BYTE_W-1:0] d, input logic l);
      int unsigned gap;
      @(negedge clock);
      if (idle_on && $urandom_range(99) < 8) begin
         gap = $urandom_range(1, 4);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      req_tlast  <= l;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      decode_byte(d, l);
   endtask

   task automatic send_stream();
      foreach (comp_stream[i]) send_item(comp_stream[i].data, comp_stream[i].last);
   endtask

   // drain: drop valid, wait for all bytes and for the decoder to settle
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (decoded_q.size() != 0) @(posedge clock);
      repeat (IDLE_GAP) @(posedge clock);
   endtask

   // arm a new stream with the given output size
   task automatic write_size(input logic [SIZE_W-1:0] v);
      wait_idle();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      dec_size   = v;
      dec_phase  = PH_TAG;
      dec_flags  = '0;
      dec_mask   = '0;
      dec_first  = '0;
      dec_count  = '0;
      dec_failed = 1'b0;
      streams_armed++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // build a well-formed stream that yields exactly size bytes
   task automatic build_stream(input int unsigned size, input int unsigned match_pct);
      int unsigned cnt;
      int unsigned room;
      int unsigned hi;
      int unsigned len;
      int unsigned distance;
      int unsigned maxd;
      int          tag_pos;
      int          slot;
      logic [7:0]  tag;
      comp_stream.delete();
      cnt = 0;
      while (cnt < size) begin
         tag_pos = comp_stream.size();
         comp_stream.insert(comp_stream.size(), comp_byte_type'{data: 8'h00, last: 1'b0});
         tag = 8'($urandom);   // unused trailing flags stay random
         for (slot = 7; slot >= 0 && cnt < size; slot--) begin
            room = size - cnt;
            if (cnt > 0 && room >= 3 && $urandom_range(99) < match_pct) begin
               tag[slot] = 1'b1;
               hi       = (room > 18) ? 18 : room;
               len      = ($urandom_range(3) == 0) ? hi : $urandom_range(3, hi);
               maxd     = (cnt > WINDOW) ? WINDOW : cnt;
               distance = ($urandom_range(7) == 0) ? maxd : $urandom_range(1, maxd);
               comp_stream.insert(comp_stream.size(), comp_byte_type'{
                  data: 8'((((len - 3) & 15) << 4) | ((distance - 1) >> 8)),
                  last: 1'b0});
               comp_stream.insert(comp_stream.size(), comp_byte_type'{
                  data: 8'((distance - 1) & 8'hFF), last: 1'b0});
               cnt += len;
            end else begin
               tag[slot] = 1'b0;
               comp_stream.insert(comp_stream.size(), comp_byte_type'{
                  data: 8'($urandom), last: 1'b0});
               cnt++;
            end
         end
         comp_stream[tag_pos].data = tag;
      end
      if (comp_stream.size() != 0) comp_stream[$].last = 1'b1;
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   // literals, short and full-length matches, a second tag, trailing bytes
   task automatic test_literals_and_matches();
      send_item(8'h00, 1'b0);      // size still 0 after reset: ignored
      send_item(8'hFF, 1'b1);
      write_size(24'd13);
      send_item(8'h40, 1'b0);      // flags: lit, match, then six literals
      send_item(8'h00, 1'b0);
      send_item(8'h00, 1'b0);      // length 3, distance 1
      send_item(8'h00, 1'b0);
      send_item(8'hFF, 1'b0);
      send_item(8'hA5, 1'b0);
      send_item(8'h5A, 1'b0);
      send_item(8'h01, 1'b0);
      send_item(8'h02, 1'b0);
      send_item(8'h03, 1'b0);
      send_item(8'h80, 1'b0);      // second tag: match first
      send_item(8'h00, 1'b0);
      send_item(8'h09, 1'b1);      // length 3, distance 10, completes
      send_item(8'h12, 1'b0);      // trailing, ignored even with last
      send_item(8'h34, 1'b1);
      write_size(24'd19);
      send_item(8'h40, 1'b0);
      send_item(8'hC3, 1'b0);
      send_item(8'hF0, 1'b0);      // length 18, exactly fills the size
      send_item(8'h00, 1'b1);
   endtask

   // every error code; the first is followed by an ignored request
   task automatic test_error_cases();
      write_size(24'd20);
      send_item(8'h80, 1'b0);
      send_item(8'hF0, 1'b0);
      send_item(8'h00, 1'b0);      // distance 1 with nothing written yet
      send_item(8'h00, 1'b1);      // failed: ignored
      write_size(24'd5);
      send_item(8'h40, 1'b0);
      send_item(8'h11, 1'b0);
      send_item(8'hF0, 1'b0);
      send_item(8'h00, 1'b0);      // 1 + 18 passes the size
      write_size(24'd25);
      send_item(8'h7F, 1'b0);
      send_item(8'h3C, 1'b0);
      send_item(8'hFF, 1'b0);
      send_item(8'hFF, 1'b0);      // distance 4096 before start
      write_size(24'd30);
      send_item(8'h00, 1'b0);
      send_item(8'h77, 1'b1);      // early end drops the literal
      write_size(24'd8);
      send_item(8'h00, 1'b1);      // early end on a tag byte
      write_size(24'd8);
      send_item(8'h40, 1'b0);
      send_item(8'h9A, 1'b0);
      send_item(8'h21, 1'b1);      // early end on a match first byte
   endtask

   // zero and largest output size
   task automatic test_size_extremes();
      write_size(24'd0);
      send_item(8'h00, 1'b0);
      send_item(8'hFF, 1'b1);
      write_size(24'hFFFFFF);
      send_item(8'h00, 1'b0);
      send_item(8'h55, 1'b0);
      send_item(8'hAA, 1'b0);
      send_item(8'hFF, 1'b1);
   endtask

   // mostly well-formed streams, some broken, some noise
   task automatic test_random_streams();
      int unsigned start;
      int unsigned done_reqs;
      int unsigned sz;
      int unsigned kind;
      int unsigned cut;
      int unsigned pos;
      int unsigned k;
      start = live_items;
      done_reqs = 0;
      while (done_reqs < RANDOM_REQS) begin
         // a stretch with no idling on either side
         idle_on = !(done_reqs >= 40 && done_reqs < 75);
         sz = ($urandom_range(9) == 0) ? $urandom_range(41, 120) : $urandom_range(1, 40);
         write_size(24'(sz));
         build_stream(sz, 50);
         kind = $urandom_range(9);
         case (kind)
            6: begin
               // truncate, with or without a final marker
               cut = $urandom_range(0, comp_stream.size() - 1);
               while (comp_stream.size() > cut + 1) void'(comp_stream.pop_back());
               comp_stream[$].last = $urandom_range(1);
            end
            7: begin
               pos = $urandom_range(0, comp_stream.size() - 1);
               comp_stream[pos].data ^= 8'(1 << $urandom_range(7));
            end
            8: begin
               k = $urandom_range(1, 4);
               repeat (k) comp_stream.insert(comp_stream.size(), comp_byte_type'{
                  data: 8'($urandom), last: 1'($urandom_range(1))});
            end
            9: begin
               comp_stream.delete();
               k = $urandom_range(4, 20);
               repeat (k) comp_stream.insert(comp_stream.size(), comp_byte_type'{
                  data: 8'($urandom), last: ($urandom_range(9) == 0)});
            end
            default: ;
         endcase
         send_stream();
         done_reqs = live_items - start;
      end
      idle_on = 1'b1;
   endtask

   // hold the receiver off while the sender keeps offering
   task automatic test_back_pressure();
      idle_on = 1'b0;
      write_size(24'd40);
      build_stream(40, 20);
      -> hold_trigger;
      send_stream();
      idle_on = 1'b1;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_literals_and_matches();
      test_error_cases();
      test_size_extremes();
      test_random_streams();
      test_back_pressure();
      wait_idle();
      $display("tb: %0d streams armed, %0d requests decoded, %0d responses checked",
               streams_armed, live_items, rsp_checked);
      $display("tb: status seen ok=%0d overrun=%0d bad_dist=%0d early_end=%0d, mismatches=%0d",
               status_seen[ST_OK], status_seen[ST_OVERRUN], status_seen[ST_BAD_DIST],
               status_seen[ST_EARLY_END], mismatches);
      if (mismatches == 0 && decoded_q.size() == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule
